FILE: hdl/bbd_pkg.sv
// ----------------------------------------------------------------------------
// bbd_pkg
// shared constants and types for the bilinear bayer demosaic core
// ----------------------------------------------------------------------------
package bbd_pkg;

  // frame geometry
  localparam int WIDTH  = 16;
  localparam int HEIGHT = 16;
  localparam int COL_W  = (WIDTH > 2) ? $clog2(WIDTH) : 1;
  localparam int ROW_W  = (HEIGHT > 2) ? $clog2(HEIGHT) : 1;
  localparam int PIX_W  = 8;

  // command queue between front and back, and result queue
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

  // one window column plus what the back end must do with it
  typedef struct packed {
    logic             clr;      // clear window before the shift
    logic             emit;     // emit a result after the shift
    logic             flush;    // then shift a zero column and emit again
    logic             run_end;  // final result of this command ends the run
    logic             eof;      // final result of this command ends the frame
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } bbd_cmd_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             end_of_run;
    logic             end_of_frame;
  } bbd_res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bbd_q_stat_t;

  typedef enum logic {
    FE_RUN,
    FE_DRAIN
  } bbd_fe_state_t;

endpackage

FILE: hdl/bbd_cmd_queue.sv
// ----------------------------------------------------------------------------
// bbd_cmd_queue
// small fifo of window column commands between front and back
// ----------------------------------------------------------------------------
module bbd_cmd_queue
  import bbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  bbd_cmd_t    push_cmd,
  input  logic        pop,
  output bbd_cmd_t    head_cmd,
  output bbd_q_stat_t stat
);

  bbd_cmd_t             mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_AW:0]     count_r, count_nxt;
  logic                 do_push, do_pop;

  assign stat.full  = (count_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == CMDQ_AW'(CMDQ_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == CMDQ_AW'(CMDQ_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: hdl/bbd_front.sv
// ----------------------------------------------------------------------------
// bbd_front
// raster tracking, line stores and column command generation
// ----------------------------------------------------------------------------
module bbd_front
  import bbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  logic [PIX_W-1:0] in_raw_pixel,
  output logic             in_full,
  input  bbd_q_stat_t      cmdq_stat,
  output logic             cmd_push,
  output bbd_cmd_t         cmd
);

  bbd_fe_state_t      state_r, state_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   drain_r, drain_nxt;
  // each entry holds {two rows up, one row up}
  logic [2*PIX_W-1:0] line_r [WIDTH];
  logic [2*PIX_W-1:0] line_rd;
  logic [COL_W-1:0]   rd_addr;
  logic               accept;
  logic               last_col, last_row, last_drain;

  assign last_col   = (col_r == COL_W'(WIDTH-1));
  assign last_row   = (row_r == ROW_W'(HEIGHT-1));
  assign last_drain = (drain_r == COL_W'(WIDTH-1));
  assign rd_addr    = (state_r == FE_DRAIN) ? drain_r : col_r;
  assign line_rd    = line_r[rd_addr];
  assign accept     = in_push && !in_full;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FE_RUN: begin
        if (accept && last_col && last_row) begin
          state_nxt = FE_DRAIN;
        end
      end
      FE_DRAIN: begin
        if (!cmdq_stat.full && last_drain) begin
          state_nxt = FE_RUN;
        end
      end
      default: state_nxt = FE_RUN;
    endcase
  end

  // outputs
  always_comb begin
    in_full  = cmdq_stat.full;
    cmd_push = 1'b0;
    cmd      = '0;
    case (state_r)
      FE_RUN: begin
        cmd_push    = accept && (row_r != '0);
        cmd.clr     = (col_r == '0);
        cmd.emit    = (col_r != '0);
        cmd.flush   = last_col;
        cmd.run_end = !(last_col && last_row);
        cmd.eof     = 1'b0;
        cmd.top     = (row_r == ROW_W'(1)) ? '0 : line_rd[2*PIX_W-1:PIX_W];
        cmd.mid     = line_rd[PIX_W-1:0];
        cmd.bot     = in_raw_pixel;
      end
      FE_DRAIN: begin
        in_full     = 1'b1;
        cmd_push    = !cmdq_stat.full;
        cmd.clr     = (drain_r == '0);
        cmd.emit    = (drain_r != '0);
        cmd.flush   = last_drain;
        cmd.run_end = last_drain;
        cmd.eof     = last_drain;
        cmd.top     = line_rd[2*PIX_W-1:PIX_W];
        cmd.mid     = line_rd[PIX_W-1:0];
        cmd.bot     = '0;
      end
      default: begin
        in_full = 1'b1;
      end
    endcase
  end

  // raster position and drain sweep
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    drain_nxt = drain_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
    if (state_r == FE_DRAIN && !cmdq_stat.full) begin
      drain_nxt = last_drain ? '0 : drain_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_RUN;
      col_r   <= '0;
      row_r   <= '0;
      drain_r <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      drain_r <= drain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_r[col_r] <= {line_rd[PIX_W-1:0], in_raw_pixel};
    end
  end

endmodule

FILE: hdl/bbd_back.sv
// ----------------------------------------------------------------------------
// bbd_back
// 3x3 window, bilinear interpolation and result queue
// ----------------------------------------------------------------------------
module bbd_back
  import bbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  bbd_cmd_t         head_cmd,
  input  bbd_q_stat_t      cmdq_stat,
  output logic             cmd_pop,
  input  logic             out_pop,
  output logic             out_empty,
  output bbd_res_t         out_res
);

  logic [PIX_W-1:0]   win_r   [3][3];
  logic [PIX_W-1:0]   win_nxt [3][3];
  logic [PIX_W-1:0]   new_col [3];
  logic               phase_r, phase_nxt;
  logic [COL_W-1:0]   ocol_r, ocol_nxt;
  logic               orow_r, orow_nxt;
  bbd_res_t           oq_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] oq_wr_r, oq_rd_r;
  logic [OUTQ_AW:0]   oq_cnt_r;
  logic               oq_full, oq_push, oq_pop;
  logic               go, clr, emit, final_res;
  logic [PIX_W+1:0]   cross_sum, diag_sum;
  logic [PIX_W:0]     vert_sum, horz_sum;
  logic [PIX_W-1:0]   cen;
  bbd_res_t           res;

  assign oq_full   = (oq_cnt_r == (OUTQ_AW+1)'(OUTQ_DEPTH));
  assign out_empty = (oq_cnt_r == '0);
  assign out_res   = oq_r[oq_rd_r];
  assign oq_pop    = out_pop && !out_empty;

  assign go        = !cmdq_stat.empty && !oq_full;
  assign clr       = !phase_r && head_cmd.clr;
  assign emit      = phase_r || head_cmd.emit;
  assign final_res = phase_r || !head_cmd.flush;
  assign cmd_pop   = go && final_res;
  assign oq_push   = go && emit;
  assign phase_nxt = go ? (!phase_r && head_cmd.flush) : phase_r;

  assign new_col[0] = phase_r ? '0 : head_cmd.top;
  assign new_col[1] = phase_r ? '0 : head_cmd.mid;
  assign new_col[2] = phase_r ? '0 : head_cmd.bot;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = clr ? '0 : win_r[i][1];
      win_nxt[i][1] = clr ? '0 : win_r[i][2];
      win_nxt[i][2] = new_col[i];
    end
  end

  // interpolation on the window after the shift
  always_comb begin
    cross_sum = (PIX_W+2)'(win_nxt[0][1]) + (PIX_W+2)'(win_nxt[1][0])
              + (PIX_W+2)'(win_nxt[1][2]) + (PIX_W+2)'(win_nxt[2][1]);
    diag_sum  = (PIX_W+2)'(win_nxt[0][0]) + (PIX_W+2)'(win_nxt[0][2])
              + (PIX_W+2)'(win_nxt[2][0]) + (PIX_W+2)'(win_nxt[2][2]);
    vert_sum  = (PIX_W+1)'(win_nxt[0][1]) + (PIX_W+1)'(win_nxt[2][1]);
    horz_sum  = (PIX_W+1)'(win_nxt[1][0]) + (PIX_W+1)'(win_nxt[1][2]);
    cen       = win_nxt[1][1];
    res       = '0;
    case ({orow_r, ocol_r[0]})
      2'b00: begin
        res.red   = vert_sum[PIX_W:1];
        res.green = cen;
        res.blue  = horz_sum[PIX_W:1];
      end
      2'b01: begin
        res.red   = diag_sum[PIX_W+1:2];
        res.green = cross_sum[PIX_W+1:2];
        res.blue  = cen;
      end
      2'b10: begin
        res.red   = cen;
        res.green = cross_sum[PIX_W+1:2];
        res.blue  = diag_sum[PIX_W+1:2];
      end
      default: begin
        res.red   = horz_sum[PIX_W:1];
        res.green = cen;
        res.blue  = vert_sum[PIX_W:1];
      end
    endcase
    res.end_of_run   = final_res && head_cmd.run_end;
    res.end_of_frame = final_res && head_cmd.eof;
  end

  // output raster position
  always_comb begin
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    if (oq_push) begin
      if (res.end_of_frame) begin
        ocol_nxt = '0;
        orow_nxt = 1'b0;
      end else if (ocol_r == COL_W'(WIDTH-1)) begin
        ocol_nxt = '0;
        orow_nxt = !orow_r;
      end else begin
        ocol_nxt = ocol_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= 1'b0;
      ocol_r   <= '0;
      orow_r   <= 1'b0;
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      ocol_r  <= ocol_nxt;
      orow_r  <= orow_nxt;
      if (oq_push) begin
        oq_wr_r <= (oq_wr_r == OUTQ_AW'(OUTQ_DEPTH-1)) ? '0 : oq_wr_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_r <= (oq_rd_r == OUTQ_AW'(OUTQ_DEPTH-1)) ? '0 : oq_rd_r + 1'b1;
      end
      if (oq_push && !oq_pop) begin
        oq_cnt_r <= oq_cnt_r + 1'b1;
      end else if (oq_pop && !oq_push) begin
        oq_cnt_r <= oq_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= win_nxt[i][j];
        end
      end
    end
    if (oq_push) begin
      oq_r[oq_wr_r] <= res;
    end
  end

endmodule

FILE: hdl/bayer_bilinear_demosaic_core.sv
// path: a window's command is registered in the command queue, then its result in the result queue
// throughput: one item per cycle on a frame's first row while the command queue has room; on later rows
//   the back end falls behind the pixels (column 0 gives no result, the row end shifts twice), so in_full
//   rises about once a row after the command queue fills; the final pixel holds in_full high
//   while the line stores are swept to drain the last row
// reset: rst_n synchronous, active low; clears raster position, queues and drain state
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_core
// streaming 3x3 bilinear bayer demosaic with queue style ports
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic_core
  import bbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // input item channel
  input  logic             in_push,
  output logic             in_full,
  input  logic [PIX_W-1:0] in_raw_pixel,
  // result item channel
  output logic             out_empty,
  input  logic             out_pop,
  output logic [PIX_W-1:0] out_red,
  output logic [PIX_W-1:0] out_green,
  output logic [PIX_W-1:0] out_blue,
  output logic             out_end_of_run,
  output logic             out_end_of_frame
);

  // front side: raster counters, line stores, column commands
  bbd_q_stat_t cmdq_stat;
  bbd_cmd_t    fe_cmd;
  bbd_cmd_t    head_cmd;
  logic        cmdq_push;
  logic        cmdq_pop;
  bbd_res_t    res;

  bbd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_raw_pixel (in_raw_pixel),
    .in_full      (in_full),
    .cmdq_stat    (cmdq_stat),
    .cmd_push     (cmdq_push),
    .cmd          (fe_cmd)
  );

  // decoupling queue: lets the back end stall on the output side
  // while the front keeps taking pixels
  bbd_cmd_queue u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmdq_push),
    .push_cmd (fe_cmd),
    .pop      (cmdq_pop),
    .head_cmd (head_cmd),
    .stat     (cmdq_stat)
  );

  // back side: window shift, interpolation, result queue
  bbd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_cmd  (head_cmd),
    .cmdq_stat (cmdq_stat),
    .cmd_pop   (cmdq_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_res   (res)
  );

  assign out_red          = res.red;
  assign out_green        = res.green;
  assign out_blue         = res.blue;
  assign out_end_of_run   = res.end_of_run;
  assign out_end_of_frame = res.end_of_frame;

  // the frame's last result always closes the run of its item
  a_eof_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_end_of_frame) |-> out_end_of_run)
    else $error("end_of_frame without end_of_run");

  // front never pushes a column into a full command queue
  a_cmdq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmdq_push |-> !cmdq_stat.full)
    else $error("command queue overflow");

  // back never retires a command that is not there
  a_cmdq_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmdq_pop |-> !cmdq_stat.empty)
    else $error("command queue underflow");

endmodule

FILE: tb/demosaic_checker.sv
// ----------------------------------------------------------------------------
// demosaic_checker
// watches both queue ports of the demosaic core, predicts every rgb item from
// the accepted raw pixels and compares each popped item field by field
// ----------------------------------------------------------------------------
module demosaic_checker
  import bbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  logic             in_full,
  input  logic [PIX_W-1:0] in_raw_pixel,
  input  logic             out_empty,
  input  logic             out_pop,
  input  logic [PIX_W-1:0] out_red,
  input  logic [PIX_W-1:0] out_green,
  input  logic [PIX_W-1:0] out_blue,
  input  logic             out_end_of_run,
  input  logic             out_end_of_frame,
  output int unsigned      fail_count,
  output int unsigned      rgb_pending
);

  localparam int unsigned FRAME_PIX = WIDTH * HEIGHT;

  logic [PIX_W-1:0] line_two_up [WIDTH];
  logic [PIX_W-1:0] line_one_up [WIDTH];
  logic [PIX_W-1:0] win [9];
  int unsigned      row_pos, col_pos, rgb_pos;

  bbd_res_t    rgb_due [$];
  bbd_res_t    want;
  int unsigned misses = 0;
  int unsigned popped = 0;

  function automatic void win_clear();
    foreach (win[i]) win[i] = '0;
  endfunction

  // newest column enters on the right
  function automatic void win_shift(logic [PIX_W-1:0] t, logic [PIX_W-1:0] m,
                                    logic [PIX_W-1:0] b);
    win[0] = win[1]; win[1] = win[2]; win[2] = t;
    win[3] = win[4]; win[4] = win[5]; win[5] = m;
    win[6] = win[7]; win[7] = win[8]; win[8] = b;
  endfunction

  // interpolate the window centre by bayer phase
  function automatic void push_rgb();
    int unsigned orow, ocol, plus_sum, diag_sum, vert_avg, horz_avg;
    int unsigned rr, gg, bb;
    bbd_res_t    res;
    orow     = rgb_pos / WIDTH;
    ocol     = rgb_pos % WIDTH;
    plus_sum = 32'(win[1]) + 32'(win[3]) + 32'(win[5]) + 32'(win[7]);
    diag_sum = 32'(win[0]) + 32'(win[2]) + 32'(win[6]) + 32'(win[8]);
    vert_avg = (32'(win[1]) + 32'(win[7])) >> 1;
    horz_avg = (32'(win[3]) + 32'(win[5])) >> 1;
    if (orow[0] == 1'b0 && ocol[0] == 1'b0) begin
      rr = vert_avg; gg = 32'(win[4]); bb = horz_avg;
    end else if (orow[0] == 1'b0) begin
      rr = diag_sum >> 2; gg = plus_sum >> 2; bb = 32'(win[4]);
    end else if (ocol[0] == 1'b0) begin
      rr = 32'(win[4]); gg = plus_sum >> 2; bb = diag_sum >> 2;
    end else begin
      rr = horz_avg; gg = 32'(win[4]); bb = vert_avg;
    end
    res.red          = rr[PIX_W-1:0];
    res.green        = gg[PIX_W-1:0];
    res.blue         = bb[PIX_W-1:0];
    res.end_of_run   = 1'b0;
    res.end_of_frame = (rgb_pos == FRAME_PIX - 1);
    rgb_due.push_back(res);
    rgb_pos++;
    if (rgb_pos >= FRAME_PIX) rgb_pos = 0;
  endfunction

  function automatic void demosaic_step(logic [PIX_W-1:0] pix);
    int unsigned      c, r, queued_at_start;
    logic [PIX_W-1:0] top, mid;
    bbd_res_t         tail;
    c   = col_pos;
    r   = row_pos;
    queued_at_start = rgb_due.size();
    top = line_two_up[c];
    mid = line_one_up[c];
    line_two_up[c] = mid;
    line_one_up[c] = pix;
    if (r != 0) begin
      if (c == 0) win_clear();
      if (r == 1) top = '0;
      win_shift(top, mid, pix);
      if (c >= 1) push_rgb();
      if (c == WIDTH - 1) begin
        win_shift('0, '0, '0);
        push_rgb();
      end
    end
    // final pixel sweeps the line stores for the last row
    if (r == HEIGHT - 1 && c == WIDTH - 1) begin
      win_clear();
      for (int unsigned k = 0; k < WIDTH; k++) begin
        win_shift(line_two_up[k], line_one_up[k], '0);
        if (k >= 1) push_rgb();
      end
      win_shift('0, '0, '0);
      push_rgb();
    end
    c++;
    if (c >= WIDTH) begin
      c = 0;
      r++;
      if (r >= HEIGHT) begin
        r       = 0;
        rgb_pos = 0;
      end
    end
    col_pos = c;
    row_pos = r;
    if (rgb_due.size() > queued_at_start) begin
      tail = rgb_due.pop_back();
      tail.end_of_run = 1'b1;
      rgb_due.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (line_two_up[i]) line_two_up[i] = '0;
      foreach (line_one_up[i]) line_one_up[i] = '0;
      win_clear();
      row_pos = 0;
      col_pos = 0;
      rgb_pos = 0;
      rgb_due.delete();
    end else begin
      if (in_push && !in_full) demosaic_step(in_raw_pixel);
      if (out_pop && !out_empty) begin
        if (rgb_due.size() == 0) begin
          misses++;
          if (misses <= 10)
            $display("item %0d popped with nothing expected: rgb %0d/%0d/%0d",
                     popped, out_red, out_green, out_blue);
        end else begin
          want = rgb_due.pop_front();
          if (out_red !== want.red || out_green !== want.green ||
              out_blue !== want.blue || out_end_of_run !== want.end_of_run ||
              out_end_of_frame !== want.end_of_frame) begin
            misses++;
            if (misses <= 10)
              $display({"item %0d: got rgb %0d/%0d/%0d run %b frame %b, ",
                        "exp %0d/%0d/%0d run %b frame %b"},
                       popped, out_red, out_green, out_blue, out_end_of_run,
                       out_end_of_frame, want.red, want.green, want.blue,
                       want.end_of_run, want.end_of_frame);
          end
        end
        popped++;
      end
    end
    fail_count  <= misses;
    rgb_pending <= rgb_due.size();
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives raw bayer frames into the demosaic core with random gaps on both
// queue ports; a separate checker predicts and compares every rgb item
// ----------------------------------------------------------------------------
module testbench;
  import bbd_pkg::*;

  localparam int unsigned DIRECTED_N = 25;
  localparam int unsigned RANDOM_N   = 385;

  // how the pixels of one random row are drawn
  typedef enum logic [1:0] {
    PAT_UNIFORM,
    PAT_EXTREME,
    PAT_FLAT,
    PAT_ONE_BIT
  } pix_pattern_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_push = 1'b0;
  logic             in_full;
  logic [PIX_W-1:0] in_raw_pixel = '0;
  logic             out_empty;
  logic             out_pop = 1'b0;
  logic [PIX_W-1:0] out_red, out_green, out_blue;
  logic             out_end_of_run, out_end_of_frame;

  int unsigned fail_count, rgb_pending;
  bit          src_steady = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bayer_bilinear_demosaic_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_raw_pixel     (in_raw_pixel),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_end_of_run   (out_end_of_run),
    .out_end_of_frame (out_end_of_frame)
  );

  demosaic_checker rgb_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_raw_pixel     (in_raw_pixel),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_end_of_run   (out_end_of_run),
    .out_end_of_frame (out_end_of_frame),
    .fail_count       (fail_count),
    .rgb_pending      (rgb_pending)
  );

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [PIX_W-1:0] row_pixel(pix_pattern_t pat,
                                                 logic [PIX_W-1:0] flat_val);
    case (pat)
      PAT_UNIFORM: return PIX_W'($urandom_range(0, 255));
      PAT_EXTREME: return $urandom_range(0, 1) ? 8'hff : 8'h00;
      PAT_FLAT:    return flat_val;
      default:     return 8'h01 << $urandom_range(0, 7);
    endcase
  endfunction

  // hold the item until the core takes it, then maybe idle
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    int unsigned idle;
    in_push      <= 1'b1;
    in_raw_pixel <= pix;
    @(posedge clk);
    while (in_full) @(posedge clk);
    idle = src_steady ? 0 : idle_len();
    if (idle != 0) begin
      in_push <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  // hard stop in case the core hangs
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // result side: random stalls with occasional stretches of steady popping
  initial begin
    int unsigned idle, burst_left;
    bit          sink_steady;
    burst_left  = 0;
    sink_steady = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (burst_left == 0) begin
        sink_steady = ($urandom_range(0, 3) == 0);
        burst_left  = 24;
      end
      burst_left--;
      idle = sink_steady ? 0 : idle_len();
      if (idle != 0) begin
        out_pop <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
    end
  end

  // pixel side and verdict
  initial begin
    int unsigned      sent;
    pix_pattern_t     pat;
    logic [PIX_W-1:0] flat_val;
    logic [PIX_W-1:0] pix;
    sent     = 0;
    pat      = PAT_UNIFORM;
    flat_val = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: walking one and walking zero across the top row, then full scale
    // swings into the second row, where the left border and first results land
    for (int unsigned i = 0; i < DIRECTED_N; i++) begin
      if (i < 8)
        pix = 8'h01 << i;
      else if (i < 16)
        pix = ~(8'h01 << (i - 8));
      else
        pix = i[0] ? 8'h00 : 8'hff;
      send_pixel(pix);
      sent++;
    end

    // random rows on past the end of the first frame, so the final
    // pixel drain and the frame restart are both hit
    while (sent < DIRECTED_N + RANDOM_N) begin
      if (sent % WIDTH == 0) begin
        pat        = pix_pattern_t'($urandom_range(0, 3));
        flat_val   = PIX_W'($urandom_range(0, 255));
        src_steady = ($urandom_range(0, 4) == 0);
      end
      send_pixel(row_pixel(pat, flat_val));
      sent++;
    end
    in_push <= 1'b0;

    // wait out the remaining rgb items, then a margin for strays
    @(posedge clk);
    while (rgb_pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (fail_count == 0 && rgb_pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
